// File: rtl/rqse_pkg.sv
// Shared types, constants and controller/datapath interface of the record quicksort engine.
package rqse_pkg;

   localparam int MAX_RECORDS = 32;
   localparam int KEY_BITS    = 16;
   localparam int TAG_BITS    = 8;
   localparam int IDX_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int SIDX_W      = CNT_W + 1;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic signed [SIDX_W-1:0] sidx_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] sort_key;
      logic [TAG_BITS-1:0] record_tag;
      logic                is_final;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] out_key;
      logic [TAG_BITS-1:0] out_tag;
      logic                out_final;
      logic                overflowed;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } rec_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   typedef enum logic [2:0] {
      RA_K,
      RA_K_INC,
      RA_STK_HI,
      RA_I,
      RA_I_INC,
      RA_J,
      RA_J_DEC
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_POP,
      ST_RANGE,
      ST_PIVOT,
      ST_SCAN_I,
      ST_SCAN_J,
      ST_SWAP_I,
      ST_SWAP_J,
      ST_NEXT,
      ST_PUSH_R,
      ST_PUSH_L,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       pop;
      logic       range_latch;
      logic       pivot_latch;
      logic       i_inc;
      logic       j_dec;
      logic       reci_latch;
      logic       recj_latch;
      logic       wr_i;
      logic       wr_j;
      logic       push_r;
      logic       push_l;
      logic       out_load;
      logic       out_done;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic sp_zero;
      logic range_ok;
      logic scan_i_go;
      logic scan_j_go;
      logic i_le_j;
      logic push_r_ok;
      logic push_l_ok;
      logic out_slot_free;
      logic out_last;
   } stat_type;

endpackage

// File: rtl/rqse_dp.sv
// Datapath: record store, range stack, partition indices and result register.
module rqse_dp (
   input  logic              clock,
   input  logic              reset,
   input  rqse_pkg::req_type req_data,
   input  rqse_pkg::cmd_type cmd,
   input  logic              rsp_ready,
   output rqse_pkg::stat_type stat,
   output logic              rsp_valid,
   output rqse_pkg::rsp_type rsp_data
);

   rqse_pkg::rec_type   rec_mem [rqse_pkg::MAX_RECORDS];
   rqse_pkg::range_type stk_mem [rqse_pkg::MAX_RECORDS];

   rqse_pkg::rec_type   rd_ff;
   rqse_pkg::range_type stk_rd_ff;
   rqse_pkg::cnt_type   cnt_ff, cnt_in;
   rqse_pkg::cnt_type   sp_ff, sp_in;
   rqse_pkg::cnt_type   k_ff, k_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rqse_pkg::rsp_type   rsp_ff, rsp_in;
   rqse_pkg::idx_type   lo_ff, lo_in, hi_ff, hi_in;
   rqse_pkg::sidx_type  i_ff, i_in, j_ff, j_in;
   logic [rqse_pkg::KEY_BITS-1:0] pivot_ff, pivot_in;
   rqse_pkg::rec_type   reci_ff, reci_in, recj_ff, recj_in;

   logic                mem_we;
   rqse_pkg::idx_type   mem_waddr, mem_raddr;
   rqse_pkg::rec_type   mem_wdata;
   logic                stk_we;
   rqse_pkg::idx_type   stk_waddr, stk_raddr;
   rqse_pkg::range_type stk_wdata;
   logic                full;
   logic                sp_room;
   rqse_pkg::sidx_type  lo_s, hi_s;
   rqse_pkg::sidx_type  i_p1, j_m1;
   rqse_pkg::cnt_type   k_p1;

   assign full    = (cnt_ff == rqse_pkg::CNT_W'(rqse_pkg::MAX_RECORDS));
   assign sp_room = (sp_ff < rqse_pkg::CNT_W'(rqse_pkg::MAX_RECORDS));
   assign lo_s    = $signed({{(rqse_pkg::SIDX_W - rqse_pkg::IDX_W){1'b0}}, lo_ff});
   assign hi_s    = $signed({{(rqse_pkg::SIDX_W - rqse_pkg::IDX_W){1'b0}}, hi_ff});
   assign i_p1    = i_ff + rqse_pkg::SIDX_W'(1);
   assign j_m1    = j_ff - rqse_pkg::SIDX_W'(1);
   assign k_p1    = k_ff + rqse_pkg::CNT_W'(1);

   // record store: one write port, one registered read port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff[rqse_pkg::IDX_W-1:0];
      mem_wdata = '{key: req_data.sort_key, tag: req_data.record_tag};
      if (cmd.load && !full) begin
         mem_we = 1'b1;
      end else if (cmd.wr_i) begin
         mem_we    = 1'b1;
         mem_waddr = i_ff[rqse_pkg::IDX_W-1:0];
         mem_wdata = recj_ff;
      end else if (cmd.wr_j) begin
         mem_we    = 1'b1;
         mem_waddr = j_ff[rqse_pkg::IDX_W-1:0];
         mem_wdata = reci_ff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         rqse_pkg::RA_K:      mem_raddr = k_ff[rqse_pkg::IDX_W-1:0];
         rqse_pkg::RA_K_INC:  mem_raddr = k_p1[rqse_pkg::IDX_W-1:0];
         rqse_pkg::RA_STK_HI: mem_raddr = stk_rd_ff.hi;
         rqse_pkg::RA_I:      mem_raddr = i_ff[rqse_pkg::IDX_W-1:0];
         rqse_pkg::RA_I_INC:  mem_raddr = i_p1[rqse_pkg::IDX_W-1:0];
         rqse_pkg::RA_J:      mem_raddr = j_ff[rqse_pkg::IDX_W-1:0];
         rqse_pkg::RA_J_DEC:  mem_raddr = j_m1[rqse_pkg::IDX_W-1:0];
         default:             mem_raddr = k_ff[rqse_pkg::IDX_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= rec_mem[mem_raddr];
   end

   // range stack: push at sp, pop reads sp-1
   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = sp_ff[rqse_pkg::IDX_W-1:0];
      stk_wdata = '{lo: i_ff[rqse_pkg::IDX_W-1:0], hi: hi_ff};
      if (cmd.init) begin
         stk_we    = (cnt_ff > rqse_pkg::CNT_W'(1));
         stk_waddr = '0;
         stk_wdata = '{lo: '0, hi: rqse_pkg::IDX_W'(cnt_ff - rqse_pkg::CNT_W'(1))};
      end else if (cmd.push_r) begin
         stk_we = sp_room;
      end else if (cmd.push_l) begin
         stk_we    = sp_room;
         stk_wdata = '{lo: lo_ff, hi: j_ff[rqse_pkg::IDX_W-1:0]};
      end
   end

   assign stk_raddr = rqse_pkg::IDX_W'(sp_ff - rqse_pkg::CNT_W'(1));

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   // counters and flags
   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + rqse_pkg::CNT_W'(1);
         end
      end
      if (cmd.init) begin
         sp_in = (cnt_ff > rqse_pkg::CNT_W'(1)) ? rqse_pkg::CNT_W'(1) : '0;
      end else if (cmd.pop) begin
         sp_in = sp_ff - rqse_pkg::CNT_W'(1);
      end else if ((cmd.push_r || cmd.push_l) && sp_room) begin
         sp_in = sp_ff + rqse_pkg::CNT_W'(1);
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         k_in         = k_p1;
      end
      if (cmd.out_done) begin
         cnt_in = '0;
         ovf_in = 1'b0;
         sp_in  = '0;
         k_in   = '0;
      end
   end

   // partition registers and result payload
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      pivot_in = pivot_ff;
      reci_in  = reci_ff;
      recj_in  = recj_ff;
      rsp_in   = rsp_ff;
      if (cmd.range_latch) begin
         lo_in = stk_rd_ff.lo;
         hi_in = stk_rd_ff.hi;
         i_in  = $signed({{(rqse_pkg::SIDX_W - rqse_pkg::IDX_W){1'b0}}, stk_rd_ff.lo});
         j_in  = $signed({{(rqse_pkg::SIDX_W - rqse_pkg::IDX_W){1'b0}}, stk_rd_ff.hi});
      end
      if (cmd.pivot_latch) begin
         pivot_in = rd_ff.key;
      end
      if (cmd.i_inc || cmd.wr_j) begin
         i_in = i_p1;
      end
      if (cmd.j_dec || cmd.wr_j) begin
         j_in = j_m1;
      end
      if (cmd.reci_latch) begin
         reci_in = rd_ff;
      end
      if (cmd.recj_latch) begin
         recj_in = rd_ff;
      end
      if (cmd.out_load) begin
         rsp_in = '{out_key: rd_ff.key, out_tag: rd_ff.tag,
                    out_final: stat.out_last, overflowed: ovf_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      reci_ff  <= reci_in;
      recj_ff  <= recj_in;
      rsp_ff   <= rsp_in;
   end

   assign stat.sp_zero       = (sp_ff == '0);
   assign stat.range_ok      = (stk_rd_ff.lo < stk_rd_ff.hi);
   assign stat.scan_i_go     = (rd_ff.key < pivot_ff) && (i_ff < hi_s);
   assign stat.scan_j_go     = (rd_ff.key > pivot_ff) && (j_ff > lo_s);
   assign stat.i_le_j        = (i_ff <= j_ff);
   assign stat.push_r_ok     = (i_ff < hi_s);
   assign stat.push_l_ok     = (j_ff > lo_s);
   assign stat.out_slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.out_last      = (k_ff == cnt_ff - rqse_pkg::CNT_W'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ovf_only_when_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flag set with room in the store");

   a_no_overwrite_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register reloaded while still held");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (sp_ff != '0))
      else $error("pop from empty range stack");

   a_swap_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_i |-> (i_ff >= lo_s) && (j_ff <= hi_s) && (i_ff <= j_ff))
      else $error("swap outside the active range");

endmodule

// File: rtl/rqse_ctrl.sv
// Controller: sequences load, partition passes of the sort and result output.
module rqse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_final,
   input  rqse_pkg::stat_type stat,
   output logic               req_ready,
   output rqse_pkg::cmd_type  cmd
);

   rqse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqse_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = rqse_pkg::RA_K;
      case (state_ff)
         rqse_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final) begin
                  state_in = rqse_pkg::ST_INIT;
               end
            end
         end
         rqse_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = rqse_pkg::ST_POP;
         end
         rqse_pkg::ST_POP: begin
            if (stat.sp_zero) begin
               state_in = rqse_pkg::ST_OUT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = rqse_pkg::ST_RANGE;
            end
         end
         rqse_pkg::ST_RANGE: begin
            if (stat.range_ok) begin
               cmd.range_latch = 1'b1;
               cmd.rd_sel      = rqse_pkg::RA_STK_HI;
               state_in        = rqse_pkg::ST_PIVOT;
            end else begin
               state_in = rqse_pkg::ST_POP;
            end
         end
         rqse_pkg::ST_PIVOT: begin
            cmd.pivot_latch = 1'b1;
            cmd.rd_sel      = rqse_pkg::RA_I;
            state_in        = rqse_pkg::ST_SCAN_I;
         end
         rqse_pkg::ST_SCAN_I: begin
            if (stat.scan_i_go) begin
               cmd.i_inc  = 1'b1;
               cmd.rd_sel = rqse_pkg::RA_I_INC;
            end else begin
               cmd.reci_latch = 1'b1;
               cmd.rd_sel     = rqse_pkg::RA_J;
               state_in       = rqse_pkg::ST_SCAN_J;
            end
         end
         rqse_pkg::ST_SCAN_J: begin
            if (stat.scan_j_go) begin
               cmd.j_dec  = 1'b1;
               cmd.rd_sel = rqse_pkg::RA_J_DEC;
            end else begin
               cmd.recj_latch = 1'b1;
               state_in = stat.i_le_j ? rqse_pkg::ST_SWAP_I : rqse_pkg::ST_PUSH_R;
            end
         end
         rqse_pkg::ST_SWAP_I: begin
            cmd.wr_i = 1'b1;
            state_in = rqse_pkg::ST_SWAP_J;
         end
         rqse_pkg::ST_SWAP_J: begin
            cmd.wr_j = 1'b1;
            state_in = rqse_pkg::ST_NEXT;
         end
         rqse_pkg::ST_NEXT: begin
            if (stat.i_le_j) begin
               cmd.rd_sel = rqse_pkg::RA_I;
               state_in   = rqse_pkg::ST_SCAN_I;
            end else begin
               state_in = rqse_pkg::ST_PUSH_R;
            end
         end
         rqse_pkg::ST_PUSH_R: begin
            cmd.push_r = stat.push_r_ok;
            state_in   = rqse_pkg::ST_PUSH_L;
         end
         rqse_pkg::ST_PUSH_L: begin
            cmd.push_l = stat.push_l_ok;
            state_in   = rqse_pkg::ST_POP;
         end
         rqse_pkg::ST_OUT: begin
            if (stat.out_slot_free) begin
               cmd.out_load = 1'b1;
               if (stat.out_last) begin
                  cmd.out_done = 1'b1;
                  state_in     = rqse_pkg::ST_LOAD;
               end else begin
                  cmd.rd_sel = rqse_pkg::RA_K_INC;
               end
            end
         end
         default: begin
            state_in = rqse_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// File: rtl/record_quicksort_engine_unit.sv
// Top level of the record quicksort engine: controller plus datapath.
// Load: one record word per cycle; a word marked final starts the sort of the batch.
// Sort: an init step seeds the range stack; a partition pass pops a range, checks it,
//   reads the pivot, scans from both ends with swaps, then runs the two push steps.
// Output: after the last pass, one word per cycle while the consumer takes them, read
//   through the single registered read port of the record store.
// Reset (synchronous) empties the batch and the stack; stored records stay undefined.
module record_quicksort_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rqse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rqse_pkg::rsp_type rsp_data
);

   // command and status bundles between controller and datapath
   rqse_pkg::cmd_type  cmd;
   rqse_pkg::stat_type stat;

   // Controller: accepts words only while loading; walks the partition steps
   // (pop range, read pivot, scan left, scan right, swap, push subranges) and
   // drains the sorted store into the result register.
   rqse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_data.is_final),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Datapath: record store and range stack memories, index registers,
   // and the result register, which holds a word until the consumer takes it
   // while the controller is already free to load the next batch.
   rqse_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/record_quicksort_engine_unit_tb.sv
// Self-checking testbench for the record quicksort engine top level.
`timescale 1ns / 1ps

module record_quicksort_engine_unit_tb;

   // Cycles with no accepted word before the run is declared hung. A 32-record
   // sort in its worst order plus the long receiver hold stay well below this.
   localparam int QUIET_LIMIT  = 20000;
   // Length of the receiver hold-off in the backpressure test.
   localparam int HOLD_CYCLES  = 1200;
   // Words offered per randomized idling phase (whole batches, so it overshoots).
   localparam int PHASE_WORDS  = 70;
   // Quiet cycles to watch for stray words once every expected word arrived.
   localparam int TAIL_CYCLES  = 40;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rqse_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rqse_pkg::rsp_type rsp_data;

   // Idling knobs: percent chance of a sender gap per cycle and of a receiver
   // stall per cycle.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_ask      = 1'b0;
   int unsigned hold_left     = 0;

   // Shadow of the block: the batch being loaded and the sorted words still owed.
   rqse_pkg::rec_type batch_recs [rqse_pkg::MAX_RECORDS];
   int                batch_len  = 0;
   logic              batch_cut  = 1'b0;
   rqse_pkg::rsp_type sorted_q [$];

   int unsigned quiet_cycles  = 0;
   int unsigned error_count   = 0;
   int unsigned words_in      = 0;
   int unsigned words_checked = 0;
   int unsigned batch_count   = 0;
   int unsigned cut_count     = 0;

   record_quicksort_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Sort the shadow batch in place exactly as the engine does: Hoare-style
   // partition around the rightmost key, index guards on both scans, and an
   // explicit range stack that silently drops pushes once it is full.
   function automatic void quicksort_batch();
      int                            lo_stk [rqse_pkg::MAX_RECORDS];
      int                            hi_stk [rqse_pkg::MAX_RECORDS];
      int                            depth;
      int                            lo;
      int                            hi;
      int                            i;
      int                            j;
      logic [rqse_pkg::KEY_BITS-1:0] pivot;
      rqse_pkg::rec_type             held;
      depth = 0;
      if (batch_len > 1) begin
         lo_stk[0] = 0;
         hi_stk[0] = batch_len - 1;
         depth = 1;
      end
      while (depth > 0) begin
         depth--;
         lo = lo_stk[depth];
         hi = hi_stk[depth];
         if (lo < 0 || hi >= batch_len || lo >= hi)
            continue;
         pivot = batch_recs[hi].key;
         i = lo;
         j = hi;
         while (i <= j) begin
            while (batch_recs[i].key < pivot && i < hi)
               i++;
            while (batch_recs[j].key > pivot && j > lo)
               j--;
            if (i <= j) begin
               held          = batch_recs[i];
               batch_recs[i] = batch_recs[j];
               batch_recs[j] = held;
               i++;
               j--;
            end
         end
         // Push the right range first so the left one is popped next.
         if (i < hi && depth < rqse_pkg::MAX_RECORDS) begin
            lo_stk[depth] = i;
            hi_stk[depth] = hi;
            depth++;
         end
         if (j > lo && depth < rqse_pkg::MAX_RECORDS) begin
            lo_stk[depth] = lo;
            hi_stk[depth] = j;
            depth++;
         end
      end
   endfunction

   // Fold one accepted word into the shadow batch; on the final word, sort and
   // queue the whole sorted batch as expected output words.
   function automatic void load_record(input rqse_pkg::req_type w);
      rqse_pkg::rsp_type r;
      if (batch_len < rqse_pkg::MAX_RECORDS) begin
         batch_recs[batch_len].key = w.sort_key;
         batch_recs[batch_len].tag = w.record_tag;
         batch_len++;
      end else begin
         batch_cut = 1'b1;
      end
      if (w.is_final) begin
         quicksort_batch();
         for (int k = 0; k < batch_len; k++) begin
            r.out_key    = batch_recs[k].key;
            r.out_tag    = batch_recs[k].tag;
            r.out_final  = (k == batch_len - 1);
            r.overflowed = batch_cut;
            sorted_q.push_back(r);
         end
         batch_count++;
         if (batch_cut)
            cut_count++;
         batch_len = 0;
         batch_cut = 1'b0;
      end
   endfunction

   // Offer one word. Valid stays high from the previous word when no gap is
   // drawn, so back-to-back words never lower and raise valid in one step.
   task automatic send_record(input logic [rqse_pkg::KEY_BITS-1:0] key,
                              input logic [rqse_pkg::TAG_BITS-1:0] tag,
                              input logic fin);
      rqse_pkg::req_type w;
      int unsigned       gap;
      w.sort_key   = key;
      w.record_tag = tag;
      w.is_final   = fin;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!(req_valid && req_ready))
         @(posedge clock);
      words_in++;
      load_record(w);
   endtask

   // Drop valid and wait until every sorted word owed so far has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sorted_q.size() != 0)
         @(posedge clock);
   endtask

   // Send one batch of random records; the key spread is drawn per batch so
   // some batches are dense with ties.
   task automatic send_random_batch(input int len);
      int unsigned                   span;
      int unsigned                   pick;
      logic [rqse_pkg::KEY_BITS-1:0] key;
      pick = $urandom_range(3);
      span = (pick == 0) ? 1 : (pick == 1) ? 7 : 0;
      for (int k = 0; k < len; k++) begin
         key = (span == 0) ? rqse_pkg::KEY_BITS'($urandom)
                           : rqse_pkg::KEY_BITS'($urandom_range(span));
         send_record(key, rqse_pkg::TAG_BITS'($urandom), k == len - 1);
      end
   endtask

   // Check each accepted result word against the oldest expectation.
   always @(posedge clock) begin : result_check
      rqse_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_q.size() == 0) begin
            $error("unexpected result word: key %0h tag %0h", rsp_data.out_key,
                   rsp_data.out_tag);
            error_count++;
         end else begin
            want = sorted_q.pop_front();
            words_checked++;
            if (rsp_data.out_key !== want.out_key) begin
               $error("out_key: expected %0h, got %0h", want.out_key, rsp_data.out_key);
               error_count++;
            end
            if (rsp_data.out_tag !== want.out_tag) begin
               $error("out_tag: expected %0h, got %0h", want.out_tag, rsp_data.out_tag);
               error_count++;
            end
            if (rsp_data.out_final !== want.out_final) begin
               $error("out_final: expected %0b, got %0b", want.out_final,
                      rsp_data.out_final);
               error_count++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, got %0b", want.overflowed,
                      rsp_data.overflowed);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off counted here once it is asked.
   always @(posedge clock) begin : receiver
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("record_quicksort_engine_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Lone final word: a batch of one, at both extremes of key and tag.
   task automatic test_lone_word();
      send_record('1, '1, 1'b1);
      send_record('0, '0, 1'b1);
      wait_drain();
   endtask

   // Extreme and sign-boundary keys and tags in one mixed batch.
   task automatic test_field_extremes();
      send_record(16'hFFFF, 8'h00, 1'b0);
      send_record(16'h0000, 8'hFF, 1'b0);
      send_record(16'h8000, 8'h80, 1'b0);
      send_record(16'h7FFF, 8'h7F, 1'b0);
      send_record(16'h0001, 8'h01, 1'b1);
      wait_drain();
   endtask

   // Equal keys: ties land where the partition leaves them, tags tell them apart.
   task automatic test_equal_keys();
      for (int k = 0; k < 4; k++)
         send_record(16'h1234, rqse_pkg::TAG_BITS'(k + 1), k == 3);
      send_record(16'd5, 8'h10, 1'b0);
      send_record(16'd5, 8'h20, 1'b0);
      send_record(16'd3, 8'h30, 1'b0);
      send_record(16'd5, 8'h40, 1'b1);
      wait_drain();
   endtask

   // Already sorted and reverse sorted runs.
   task automatic test_ordered_runs();
      for (int k = 0; k < 4; k++)
         send_record(rqse_pkg::KEY_BITS'(k), rqse_pkg::TAG_BITS'(8'hA0 + k), k == 3);
      for (int k = 0; k < 4; k++)
         send_record(rqse_pkg::KEY_BITS'(3 - k), rqse_pkg::TAG_BITS'(8'hB0 + k), k == 3);
      wait_drain();
   endtask

   // Store exactly full, then overfull with the final word itself dropped,
   // then a short batch to show the cut flag has cleared.
   task automatic test_store_limits();
      send_random_batch(rqse_pkg::MAX_RECORDS);
      send_random_batch(rqse_pkg::MAX_RECORDS + 2);
      send_random_batch(3);
      wait_drain();
   endtask

   // Random batches under one idling mix; lengths lean to the interesting sizes.
   task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall_pct);
      int unsigned sent_here;
      int unsigned pick;
      int          len;
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
      sent_here = 0;
      while (sent_here < PHASE_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 10)
            len = 1;
         else if (pick < 20)
            len = rqse_pkg::MAX_RECORDS;
         else if (pick < 27)
            len = $urandom_range(rqse_pkg::MAX_RECORDS + 8, rqse_pkg::MAX_RECORDS + 1);
         else
            len = $urandom_range(rqse_pkg::MAX_RECORDS - 1, 2);
         send_random_batch(len);
         sent_here += len;
      end
      wait_drain();
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering
   // words: the output stalls and the engine must stall its input in turn.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_ask <= 1'b1;
      @(posedge clock);
      hold_ask <= 1'b0;
      send_random_batch(rqse_pkg::MAX_RECORDS);
      send_random_batch(12);
      wait_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lone_word();
      test_field_extremes();
      test_equal_keys();
      test_ordered_runs();
      test_store_limits();
      test_random_phase(0, 0);
      test_random_phase(69, 0);
      test_random_phase(0, 69);
      test_random_phase(11, 11);
      test_backpressure();

      // Watch for stray words after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sorted %0d batches (%0d cut short at the store limit) from %0d words in;",
               batch_count, cut_count, words_in);
      $display("checked %0d result words under idle, stall and long hold-off mixes",
               words_checked);
      if (error_count == 0)
         $display("record_quicksort_engine_unit_tb: clean");
      else
         $display("record_quicksort_engine_unit_tb: errors");
      $finish;
   end

endmodule
